### hdl/elite_top_k_selector_core_defines.svh
// Assertion macros shared by the elite selector RTL.
`ifndef ELITE_TOP_K_SELECTOR_CORE_DEFINES_SVH
`define ELITE_TOP_K_SELECTOR_CORE_DEFINES_SVH
`ifndef NO_ASSERTIONS
// Same-cycle implication, checked out of reset.
`define ETKS_ASSERT_NOW(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("etks check failed");
// Next-cycle implication, checked out of reset.
`define ETKS_ASSERT_NEXT(label, ante, cons) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("etks check failed");
`else
`define ETKS_ASSERT_NOW(label, ante, cons)
`define ETKS_ASSERT_NEXT(label, ante, cons)
`endif
`endif

### hdl/etks_pkg.sv
// Shared types for the elite selector: cell control bundle, field widths and register indexes.
`timescale 1ns / 1ps
package etks_pkg;

	localparam int FIT_W   = 32;
	localparam int SEL_W   = 10;
	localparam int RANK_W  = 4;
	localparam int KEEP_W  = 5;
	localparam int POPC_W  = 11;
	localparam int CFG_W   = 11;

	// Register indexes of the configuration port
	localparam logic REG_KEEP_COUNT = 1'b0;
	localparam logic REG_POP_COUNT  = 1'b1;

	// Commands broadcast to every cell of the chain
	typedef struct packed {
		logic insert;
		logic drain;
		logic clear;
	} etks_ctrl_t;

endpackage

### hdl/etks_cell.sv
// One slot of the ranked chain: holds an entry; inserts, shifts or clears on command.
`timescale 1ns / 1ps
module etks_cell import etks_pkg::*; #(
	parameter int IW = 10
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  etks_ctrl_t              ctrl,
	input  logic signed [FIT_W-1:0] new_fit,
	input  logic [IW-1:0]           new_idx,
	input  logic                    prev_take,
	input  logic                    prev_valid,
	input  logic signed [FIT_W-1:0] prev_fit,
	input  logic [IW-1:0]           prev_idx,
	input  logic                    next_valid,
	input  logic signed [FIT_W-1:0] next_fit,
	input  logic [IW-1:0]           next_idx,
	output logic                    take,
	output logic                    valid,
	output logic signed [FIT_W-1:0] fit,
	output logic [IW-1:0]           idx
);

	logic                    valid_q;
	logic signed [FIT_W-1:0] fit_q;
	logic [IW-1:0]           idx_q;

	// New item belongs here or above unless this entry is strictly better
	assign take  = !(valid_q && (fit_q > new_fit));
	assign valid = valid_q;
	assign fit   = fit_q;
	assign idx   = idx_q;

	// Valid flag: clear, shift toward the head, or insert
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (ctrl.clear) begin
			valid_q <= 1'b0;
		end else if (ctrl.drain) begin
			valid_q <= next_valid;
		end else if (ctrl.insert && take) begin
			valid_q <= prev_take ? prev_valid : 1'b1;
		end
	end

	// Entry payload follows the same moves
	always_ff @(posedge clk) begin
		if (ctrl.drain) begin
			fit_q <= next_fit;
			idx_q <= next_idx;
		end else if (ctrl.insert && take) begin
			if (prev_take) begin
				fit_q <= prev_fit;
				idx_q <= prev_idx;
			end else begin
				fit_q <= new_fit;
				idx_q <= new_idx;
			end
		end
	end

endmodule

### hdl/elite_top_k_selector_core.sv
// Elite selector top level: population counter, cell chain and result drain.
// Input: one fitness item per cycle while no population is being reported.
// Output: an item that ends a population starts the drain; the output register
// then loads one result per cycle while out_ready allows; input stalls meanwhile.
// The KEEP_MAX compare/shift cells take 1 item/cycle while not draining.
// Reset (arst_n low, asynchronous) empties the list, keep 10, population 1.
`timescale 1ns / 1ps
`include "elite_top_k_selector_core_defines.svh"
module elite_top_k_selector_core import etks_pkg::*; #(
	parameter int KEEP_MAX = 16,
	parameter int POP_MAX  = 1024
) (
	input  logic                    clk,
	input  logic                    arst_n,
	input  logic                    cfg_wr_en,
	input  logic                    cfg_index,
	input  logic [CFG_W-1:0]        cfg_data,
	input  logic                    in_valid,
	output logic                    in_ready,
	input  logic signed [FIT_W-1:0] fitness,
	output logic                    out_valid,
	input  logic                    out_ready,
	output logic [SEL_W-1:0]        selected_index,
	output logic [RANK_W-1:0]       rank,
	output logic                    last
);

	localparam int IW = $clog2(POP_MAX);
	localparam int CW = $clog2(POP_MAX + 1);
	localparam int KW = $clog2(KEEP_MAX + 1);
	localparam int RW = (KEEP_MAX > 1) ? $clog2(KEEP_MAX) : 1;

	logic [KEEP_W-1:0]       keep_count_q;
	logic [POPC_W-1:0]       population_count_q;
	logic [CW-1:0]           cnt_q;
	logic [CW-1:0]           cnt_inc;
	logic [CW-1:0]           pop_eff;
	logic [31:0]             k_wide;
	logic [KW-1:0]           k_eff;
	logic [KW-1:0]           k_q;
	logic                    drain_q;
	logic [RW-1:0]           drain_rank_q;
	logic                    in_acc;
	logic                    pop_end;
	logic                    load;
	logic                    head_last;
	logic                    out_valid_q;
	logic [SEL_W-1:0]        sel_q;
	logic [RANK_W-1:0]       rank_q;
	logic                    last_q;
	etks_ctrl_t              ctrl;

	logic                    c_take  [KEEP_MAX];
	logic                    c_valid [KEEP_MAX];
	logic signed [FIT_W-1:0] c_fit   [KEEP_MAX];
	logic [IW-1:0]           c_idx   [KEEP_MAX];

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			keep_count_q       <= KEEP_W'(10);
			population_count_q <= POPC_W'(1);
		end else if (cfg_wr_en) begin
			case (cfg_index)
				REG_KEEP_COUNT: keep_count_q       <= cfg_data[KEEP_W-1:0];
				REG_POP_COUNT:  population_count_q <= cfg_data[POPC_W-1:0];
				default:        ;
			endcase
		end
	end

	// Effective population and keep counts
	always_comb begin
		if (population_count_q == '0) begin
			pop_eff = CW'(1);
		end else if (32'(population_count_q) > 32'(POP_MAX)) begin
			pop_eff = CW'(POP_MAX);
		end else begin
			pop_eff = CW'(population_count_q);
		end
		k_wide = 32'(keep_count_q);
		if (k_wide > 32'(pop_eff)) begin
			k_wide = 32'(pop_eff);
		end
		if (k_wide > 32'(KEEP_MAX)) begin
			k_wide = 32'(KEEP_MAX);
		end
		k_eff = k_wide[KW-1:0];
	end

	assign in_ready  = !drain_q;
	assign in_acc    = in_valid && in_ready;
	assign cnt_inc   = cnt_q + CW'(1);
	assign pop_end   = (cnt_inc >= pop_eff);
	assign load      = drain_q && (!out_valid_q || out_ready);
	assign head_last = ((KW'(drain_rank_q) + KW'(1)) == k_q);

	assign ctrl.insert = in_acc;
	assign ctrl.drain  = load;
	assign ctrl.clear  = (load && head_last) || (in_acc && pop_end && (k_eff == '0));

	// Population counter and drain sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cnt_q        <= '0;
			drain_q      <= 1'b0;
			drain_rank_q <= '0;
			k_q          <= '0;
		end else begin
			if (in_acc) begin
				cnt_q <= pop_end ? '0 : cnt_inc;
				if (pop_end && (k_eff != '0)) begin
					drain_q      <= 1'b1;
					drain_rank_q <= '0;
					k_q          <= k_eff;
				end
			end
			if (load) begin
				drain_rank_q <= drain_rank_q + RW'(1);
				if (head_last) begin
					drain_q <= 1'b0;
				end
			end
		end
	end

	// Chain of ranked cells, head at index 0
	for (genvar i = 0; i < KEEP_MAX; i++) begin : g_cell
		logic                    p_take;
		logic                    p_valid;
		logic signed [FIT_W-1:0] p_fit;
		logic [IW-1:0]           p_idx;
		logic                    n_valid;
		logic signed [FIT_W-1:0] n_fit;
		logic [IW-1:0]           n_idx;

		if (i == 0) begin : g_head
			assign p_take  = 1'b0;
			assign p_valid = 1'b1;
			assign p_fit   = fitness;
			assign p_idx   = IW'(cnt_q);
		end else begin : g_body
			assign p_take  = c_take[i-1];
			assign p_valid = c_valid[i-1];
			assign p_fit   = c_fit[i-1];
			assign p_idx   = c_idx[i-1];
		end

		if (i == KEEP_MAX - 1) begin : g_tail
			assign n_valid = 1'b0;
			assign n_fit   = fitness;
			assign n_idx   = IW'(cnt_q);
		end else begin : g_mid
			assign n_valid = c_valid[i+1];
			assign n_fit   = c_fit[i+1];
			assign n_idx   = c_idx[i+1];
		end

		etks_cell #(.IW(IW)) u_cell (
			.clk        (clk),
			.arst_n     (arst_n),
			.ctrl       (ctrl),
			.new_fit    (fitness),
			.new_idx    (IW'(cnt_q)),
			.prev_take  (p_take),
			.prev_valid (p_valid),
			.prev_fit   (p_fit),
			.prev_idx   (p_idx),
			.next_valid (n_valid),
			.next_fit   (n_fit),
			.next_idx   (n_idx),
			.take       (c_take[i]),
			.valid      (c_valid[i]),
			.fit        (c_fit[i]),
			.idx        (c_idx[i])
		);
	end

	// Output register: hold a result until taken
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			sel_q  <= SEL_W'(c_idx[0]);
			rank_q <= RANK_W'(drain_rank_q);
			last_q <= head_last;
		end
	end

	assign out_valid      = out_valid_q;
	assign selected_index = sel_q;
	assign rank           = rank_q;
	assign last           = last_q;

	// Checks on the drain and the counter
	`ETKS_ASSERT_NOW(a_head_valid, drain_q, c_valid[0])
	`ETKS_ASSERT_NOW(a_drain_k, drain_q, k_q != '0)
	`ETKS_ASSERT_NEXT(a_last_ends, load && head_last, !drain_q && !c_valid[0])
	`ETKS_ASSERT_NEXT(a_cnt_step, in_acc && !pop_end, cnt_q == $past(cnt_inc))

endmodule

### sim/testbench.sv
// Self-checking testbench for the elite top-k selector: streams fitness items, checks ranked picks.
`timescale 1ns / 1ps
module testbench import etks_pkg::*;;

	localparam int KEEP_MAX      = 16;
	localparam int POP_MAX       = 1024;
	localparam int SETTLE_CYCLES = 8;
	localparam int RAND_PHASES   = 16;
	localparam int unsigned LIMIT_NS = 2_000_000;

	// One reported elite individual
	typedef struct packed {
		logic [SEL_W-1:0]  sel;
		logic [RANK_W-1:0] pos;
		logic              fin;
	} elite_pick_t;

	// Ranked-list predictor and store of pending picks
	class elite_scoreboard;
		logic [KEEP_W-1:0]        keep_reg;
		logic [POPC_W-1:0]        pop_reg;
		logic signed [FIT_W-1:0]  fit_list[KEEP_MAX];
		int                       idx_list[KEEP_MAX];
		int                       filled;
		int                       seen;
		elite_pick_t              picks[$];
		int                       mismatches;
		int                       items;
		int                       results;
		int                       populations;

		function new();
			keep_reg = 5'd10;
			pop_reg = 11'd1;
			filled = 0;
			seen = 0;
			mismatches = 0;
			items = 0;
			results = 0;
			populations = 0;
		endfunction

		function void write_reg(logic idx, logic [CFG_W-1:0] data);
			if (idx == REG_KEEP_COUNT)
				keep_reg = data[KEEP_W-1:0];
			else
				pop_reg = data[POPC_W-1:0];
		endfunction

		function int pending();
			return picks.size();
		endfunction

		// Insert the item into the ranked list; emit the elite at population end
		function void note_fitness(logic signed [FIT_W-1:0] f);
			int pos;
			int span;
			int k;
			elite_pick_t p;
			items++;
			pos = 0;
			while (pos < KEEP_MAX && pos < filled && fit_list[pos] > f)
				pos++;
			if (pos < KEEP_MAX) begin
				for (int j = KEEP_MAX - 1; j > pos; j--) begin
					fit_list[j] = fit_list[j-1];
					idx_list[j] = idx_list[j-1];
				end
				fit_list[pos] = f;
				idx_list[pos] = seen;
				if (filled < KEEP_MAX)
					filled++;
			end
			seen++;
			span = (pop_reg == 0) ? 1 : (pop_reg > POP_MAX) ? POP_MAX : int'(pop_reg);
			if (seen < span)
				return;
			k = keep_reg;
			if (k > span)
				k = span;
			if (k > KEEP_MAX)
				k = KEEP_MAX;
			if (k > filled)
				k = filled;
			for (int i = 0; i < k; i++) begin
				p.sel = idx_list[i][SEL_W-1:0];
				p.pos = i[RANK_W-1:0];
				p.fin = (i == k - 1);
				picks.push_back(p);
			end
			populations++;
			filled = 0;
			seen = 0;
		endfunction

		function void flag(string what, elite_pick_t want, elite_pick_t got);
			if (mismatches < 10)
				$display("[%0t] %s: expected index %0d rank %0d last %0d, %s %0d %s %0d %s %0d",
					$time, what, want.sel, want.pos, want.fin,
					"got index", got.sel, "rank", got.pos, "last", got.fin);
			mismatches++;
		endfunction

		// Compare one accepted result against the oldest pending pick
		function void check_result(elite_pick_t got);
			elite_pick_t want;
			results++;
			if (picks.size() == 0) begin
				flag("result with no pick pending", '0, got);
				return;
			end
			want = picks.pop_front();
			if (got.sel !== want.sel || got.pos !== want.pos || got.fin !== want.fin)
				flag("pick mismatch", want, got);
		endfunction
	endclass

	logic                    clk = 1'b0;
	logic                    arst_n = 1'b0;
	logic                    cfg_wr_en = 1'b0;
	logic                    cfg_index = REG_KEEP_COUNT;
	logic [CFG_W-1:0]        cfg_data = '0;
	logic                    in_valid = 1'b0;
	logic                    in_ready;
	logic signed [FIT_W-1:0] fitness = '0;
	logic                    out_valid;
	logic                    out_ready = 1'b0;
	logic [SEL_W-1:0]        selected_index;
	logic [RANK_W-1:0]       rank;
	logic                    last;

	elite_scoreboard sb;
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	int hold_left = 0;

	elite_top_k_selector_core uut (
		.clk            (clk),
		.arst_n         (arst_n),
		.cfg_wr_en      (cfg_wr_en),
		.cfg_index      (cfg_index),
		.cfg_data       (cfg_data),
		.in_valid       (in_valid),
		.in_ready       (in_ready),
		.fitness        (fitness),
		.out_valid      (out_valid),
		.out_ready      (out_ready),
		.selected_index (selected_index),
		.rank           (rank),
		.last           (last)
	);

	always #5 clk = ~clk;

	// Drive out_ready: honor a long hold-off first, else stall at random
	always @(negedge clk) begin
		if (hold_left > 0) begin
			out_ready = 1'b0;
			hold_left--;
		end else begin
			out_ready = ($urandom_range(0, 99) < recv_stall_pct) ? 1'b0 : 1'b1;
		end
	end

	// Check every accepted result
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			sb.check_result('{sel: selected_index, pos: rank, fin: last});
	end

	function automatic void set_idling(int mode);
		case (mode)
			0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
			1: begin send_idle_pct = 45; recv_stall_pct = 0;  end
			2: begin send_idle_pct = 0;  recv_stall_pct = 45; end
			default: begin send_idle_pct = 19; recv_stall_pct = 19; end
		endcase
	endfunction

	function automatic logic signed [FIT_W-1:0] rand_fitness();
		case ($urandom_range(0, 9))
			0: return 32'sh7FFF_FFFF;
			1: return 32'sh8000_0000;
			2, 3: return int'($urandom_range(0, 6)) - 3;
			default: return $urandom;
		endcase
	endfunction

	task automatic write_reg(input logic idx, input logic [CFG_W-1:0] data);
		@(negedge clk);
		cfg_wr_en = 1'b1;
		cfg_index = idx;
		cfg_data = data;
		@(posedge clk);
		sb.write_reg(idx, data);
		@(negedge clk);
		cfg_wr_en = 1'b0;
	endtask

	// Offer one fitness item, with an optional idle gap, and wait for acceptance
	task automatic send_fitness(input logic signed [FIT_W-1:0] f);
		@(negedge clk);
		if ($urandom_range(0, 99) < send_idle_pct) begin
			in_valid = 1'b0;
			fitness = $urandom;
			repeat ($urandom_range(1, 4)) @(negedge clk);
		end
		in_valid = 1'b1;
		fitness = f;
		do @(posedge clk); while (!in_ready);
		sb.note_fitness(f);
	endtask

	// Drop valid and wait until every pending pick has come out
	task automatic settle();
		@(negedge clk);
		in_valid = 1'b0;
		while (sb.pending() != 0)
			@(negedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	initial begin : stimulus
		int n;
		int keep_val;
		int pop_val;
		sb = new();
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		repeat (2) @(posedge clk);

		// Reset settings: one-item population, keep clamped to one
		send_fitness(32'sh8000_0000);
		settle();

		// Population count zero acts as one
		write_reg(REG_KEEP_COUNT, 11'd16);
		write_reg(REG_POP_COUNT, 11'd0);
		send_fitness(32'sh7FFF_FFFF);
		settle();

		// Oversized keep count, extremes, tie at the top
		write_reg(REG_KEEP_COUNT, 11'd31);
		write_reg(REG_POP_COUNT, 11'd5);
		send_fitness(32'sh7FFF_FFFF);
		send_fitness(32'sh8000_0000);
		send_fitness(32'sh0000_0000);
		send_fitness(-32'sd1);
		send_fitness(32'sh7FFF_FFFF);
		settle();

		// Keep count zero: population consumed silently
		write_reg(REG_KEEP_COUNT, 11'd0);
		write_reg(REG_POP_COUNT, 11'd3);
		repeat (3) send_fitness($urandom);
		settle();

		// All equal fitness, upper data bits ignored by the keep register
		write_reg(REG_KEEP_COUNT, 11'h7E3);
		write_reg(REG_POP_COUNT, 11'd4);
		repeat (4) send_fitness(32'sd5);
		settle();

		// Shrink the population below the items already taken
		write_reg(REG_KEEP_COUNT, 11'd2);
		write_reg(REG_POP_COUNT, 11'd6);
		repeat (4) send_fitness(rand_fitness());
		settle();
		write_reg(REG_KEEP_COUNT, 11'd4);
		write_reg(REG_POP_COUNT, 11'd3);
		send_fitness(rand_fitness());
		settle();

		// Random phases across idling modes and register settings
		for (int ph = 0; ph < RAND_PHASES; ph++) begin
			set_idling(ph % 4);
			case (ph)
				0: keep_val = 16;
				1: keep_val = 0;
				2: keep_val = 31;
				6: keep_val = 3;
				default: keep_val = ($urandom_range(0, 9) == 0) ?
					$urandom_range(17, 31) : $urandom_range(0, 16);
			endcase
			case (ph)
				3: pop_val = 1;
				4: pop_val = 16;
				5: pop_val = 0;
				6: pop_val = 3;
				7: pop_val = 17;
				default: pop_val = $urandom_range(1, 24);
			endcase
			// Hold the output off long enough to back the block up
			if (ph == 6)
				hold_left = 80;
			write_reg(REG_KEEP_COUNT,
				CFG_W'(($urandom & 11'h7E0) | keep_val[KEEP_W-1:0]));
			write_reg(REG_POP_COUNT, pop_val[CFG_W-1:0]);
			n = $urandom_range(14, 26);
			repeat (n) send_fitness(rand_fitness());
			settle();
		end

		// Close any partial population
		set_idling(3);
		write_reg(REG_KEEP_COUNT, 11'd1);
		write_reg(REG_POP_COUNT, 11'd1);
		send_fitness(rand_fitness());
		settle();

		// Saturated population count does not end early; shrink it to close
		write_reg(REG_KEEP_COUNT, 11'd16);
		write_reg(REG_POP_COUNT, 11'h7FF);
		repeat (40) send_fitness(rand_fitness());
		settle();
		write_reg(REG_POP_COUNT, 11'd1);
		send_fitness(rand_fitness());
		settle();

		$display("Run covered %0d fitness items in %0d populations, %0d picks checked.",
			sb.items, sb.populations, sb.results);
		$display("Keep counts 0..31 and population counts 0..2047 under idle, stall and hold-off.");
		if (sb.mismatches == 0 && sb.pending() == 0) begin
			$display("ALL CHECKS PASSED");
		end else begin
			$display("CHECKS FAILED");
		end
		$finish;
	end

	// Bound the run time
	initial begin : watchdog
		#(LIMIT_NS);
		$display("timeout with %0d picks outstanding", sb.pending());
		$display("CHECKS FAILED");
		$finish;
	end

endmodule

### elite_top_k_selector_core.f
+incdir+hdl
hdl/etks_pkg.sv
hdl/etks_cell.sv
hdl/elite_top_k_selector_core.sv
sim/testbench.sv
